[src/kfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kfd_pkg;

   localparam int MAX_FRAME_BYTES_DEF = 512;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   localparam int FRAME_LEN_W = 10;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_HEAD = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   localparam logic [7:0] FEND  = 8'hc0;
   localparam logic [7:0] FESC  = 8'hdb;
   localparam logic [7:0] TFEND = 8'hdc;
   localparam logic [7:0] TFESC = 8'hdd;
   localparam logic [7:0] SUM_OK = 8'hff;
   localparam logic [15:0] TICK_MAX = 16'hffff;

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_GOOD = 3'd1;
   localparam logic [2:0] EV_CSUM = 3'd2;
   localparam logic [2:0] EV_OVER = 3'd3;
   localparam logic [2:0] EV_TIME = 3'd4;

   typedef struct packed {
      logic [1:0]  phase;
      logic        escaped;
      logic [7:0]  byte_sum;
      logic [3:0]  header_cmd;
      logic [3:0]  header_port;
      logic        timer_running;
      logic [15:0] tick_count;
   } state_type;

   localparam state_type STATE_CLEAR = '{
      phase:         PH_IDLE,
      escaped:       1'b0,
      byte_sum:      8'd0,
      header_cmd:    4'd0,
      header_port:   4'd0,
      timer_running: 1'b0,
      tick_count:    16'd0
   };

   typedef struct packed {
      logic                   byte_valid;
      logic [7:0]             byte_out;
      logic [2:0]             event_res;
      logic [FRAME_LEN_W-1:0] frame_len;
      logic [3:0]             cmd_code;
      logic [3:0]             port_num;
   } result_type;

endpackage

`default_nettype wire

[src/kiss_frame_decoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// kiss frame decoder: takes one item per clock, either a received serial byte
// or a timer tick, and gives exactly one result item per input item. each item
// passes the input register, then the result register; unless held off, a new
// item can enter every cycle since the whole frame state update is one combinational
// step between the two registers. the result register only holds the input side off
// while a result waits for rsp_tready and the input register is also full.

module kiss_frame_decoder_core #(
   parameter int MAX_FRAME_BYTES = kfd_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,   // byte_in
   input  wire [0:0]  req_tuser,   // func
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [31:0] rsp_tdata,  // byte_out, frame_len, cmd_code, port_num, zero pad
   output logic [3:0] rsp_tuser,   // byte_valid, event_res
   input  wire        csr_wr_en,
   input  wire [15:0] csr_wr_data  // timeout_ticks
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

   logic [15:0]          timeout_ff;
   logic                 in_vld_ff;
   logic                 in_func_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_vld_ff;
   kfd_pkg::result_type  out_res_ff;
   kfd_pkg::state_type   state_ff;
   kfd_pkg::state_type   state_in;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   kfd_pkg::result_type  result;
   logic                 out_free;
   logic                 advance;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign advance    = in_vld_ff && out_free;
   assign req_tready = !in_vld_ff || advance;

   kfd_step #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .CNT_W(CNT_W)
   ) u_step (
      .func(in_func_ff),
      .byte_in(in_byte_ff),
      .timeout_ticks(timeout_ff),
      .state_cur(state_ff),
      .count_cur(count_ff),
      .state_nxt(state_in),
      .count_nxt(count_in),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= kfd_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_func_ff <= req_tuser[0];
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         state_ff   <= kfd_pkg::STATE_CLEAR;
         count_ff   <= '0;
      end else begin
         if (out_free) begin
            out_vld_ff <= in_vld_ff;
         end
         if (advance) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {6'd0, out_res_ff.port_num, out_res_ff.cmd_code,
                        out_res_ff.frame_len, out_res_ff.byte_out};
   assign rsp_tuser  = {out_res_ff.event_res, out_res_ff.byte_valid};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAME_BYTES))
      else $error("stored count beyond buffer size");

   a_abort_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (result.event_res == kfd_pkg::EV_CSUM ||
                  result.event_res == kfd_pkg::EV_OVER ||
                  result.event_res == kfd_pkg::EV_TIME)
      |=> !state_ff.timer_running && count_ff == '0 && state_ff.phase == kfd_pkg::PH_IDLE)
      else $error("abort did not clear frame state");

   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      advance && result.byte_valid |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("stored byte not counted");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_vld_ff && out_vld_ff && !rsp_tready)
      else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

[src/kfd_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module kfd_step #(
   parameter int MAX_FRAME_BYTES = kfd_pkg::MAX_FRAME_BYTES_DEF,
   parameter int CNT_W           = $clog2(MAX_FRAME_BYTES + 1)
) (
   input  wire                      func,
   input  wire [7:0]                byte_in,
   input  wire [15:0]               timeout_ticks,
   input  kfd_pkg::state_type       state_cur,
   input  wire [CNT_W-1:0]          count_cur,
   output kfd_pkg::state_type       state_nxt,
   output logic [CNT_W-1:0]         count_nxt,
   output kfd_pkg::result_type      result
);

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

   function automatic logic [kfd_pkg::FRAME_LEN_W-1:0] to_len(input logic [CNT_W-1:0] c);
      logic [CNT_W+kfd_pkg::FRAME_LEN_W-1:0] w;
      w = {{kfd_pkg::FRAME_LEN_W{1'b0}}, c};
      return w[kfd_pkg::FRAME_LEN_W-1:0];
   endfunction

   logic [15:0]      tick_inc;
   logic [7:0]       decoded;
   logic [CNT_W-1:0] count_inc;

   assign tick_inc  = (state_cur.tick_count == kfd_pkg::TICK_MAX) ?
                      state_cur.tick_count : state_cur.tick_count + 16'd1;
   assign count_inc = count_cur + CNT_W'(1);

   always_comb begin
      if (state_cur.escaped && byte_in == kfd_pkg::TFESC) begin
         decoded = kfd_pkg::FESC;
      end else if (state_cur.escaped && byte_in == kfd_pkg::TFEND) begin
         decoded = kfd_pkg::FEND;
      end else begin
         decoded = byte_in;
      end
   end

   always_comb begin
      state_nxt         = state_cur;
      count_nxt         = count_cur;
      result.byte_valid = 1'b0;
      result.byte_out   = 8'd0;
      result.event_res  = kfd_pkg::EV_NONE;
      result.frame_len  = to_len(count_cur);
      result.cmd_code   = state_cur.header_cmd;
      result.port_num   = state_cur.header_port;

      if (func) begin
         if (state_cur.timer_running) begin
            state_nxt.tick_count = tick_inc;
            if (tick_inc >= timeout_ticks) begin
               state_nxt        = kfd_pkg::STATE_CLEAR;
               count_nxt        = '0;
               result.event_res = kfd_pkg::EV_TIME;
            end
         end
      end else if (state_cur.phase == kfd_pkg::PH_HEAD) begin
         state_nxt.header_cmd  = byte_in[3:0];
         state_nxt.header_port = byte_in[7:4];
         state_nxt.phase       = kfd_pkg::PH_BODY;
         result.cmd_code       = byte_in[3:0];
         result.port_num       = byte_in[7:4];
      end else if (state_cur.phase != kfd_pkg::PH_BODY) begin
         if (byte_in == kfd_pkg::FEND) begin
            state_nxt               = kfd_pkg::STATE_CLEAR;
            state_nxt.phase         = kfd_pkg::PH_HEAD;
            state_nxt.timer_running = 1'b1;
            count_nxt               = '0;
            result.frame_len        = '0;
            result.cmd_code         = 4'd0;
            result.port_num         = 4'd0;
         end
      end else if (byte_in == kfd_pkg::FEND) begin
         if (state_cur.header_cmd != 4'd0 && state_cur.byte_sum != kfd_pkg::SUM_OK) begin
            state_nxt        = kfd_pkg::STATE_CLEAR;
            count_nxt        = '0;
            result.event_res = kfd_pkg::EV_CSUM;
         end else begin
            state_nxt.phase         = kfd_pkg::PH_IDLE;
            state_nxt.escaped       = 1'b0;
            state_nxt.timer_running = 1'b0;
            result.event_res        = kfd_pkg::EV_GOOD;
         end
      end else if (byte_in == kfd_pkg::FESC) begin
         state_nxt.escaped = 1'b1;
      end else if (count_cur >= CNT_MAX) begin
         state_nxt        = kfd_pkg::STATE_CLEAR;
         count_nxt        = '0;
         result.event_res = kfd_pkg::EV_OVER;
      end else begin
         state_nxt.escaped  = 1'b0;
         state_nxt.byte_sum = state_cur.byte_sum + decoded;
         count_nxt          = count_inc;
         result.byte_valid  = 1'b1;
         result.byte_out    = decoded;
         result.frame_len   = to_len(count_inc);
      end
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAME_CAP = kfd_pkg::MAX_FRAME_BYTES_DEF;
   localparam int CYCLE_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // byte_in
   logic [0:0]  req_tuser = 1'b0;    // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // byte_out, frame_len, cmd_code, port_num, zero pad
   logic [3:0]  rsp_tuser;           // byte_valid, event_res
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   kiss_frame_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state as predicted
   logic [1:0]  dec_phase;
   logic        dec_escaped;
   logic [7:0]  dec_sum;
   logic [9:0]  dec_len;
   logic [3:0]  dec_cmd;
   logic [3:0]  dec_port;
   logic        dec_timer_on;
   logic [15:0] dec_ticks;
   logic [15:0] dec_timeout;

   kfd_pkg::result_type pending_results[$];
   int mismatch_count = 0;
   int live_items = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit no_gaps = 1'b0;

   function automatic void clear_frame();
      dec_phase = kfd_pkg::PH_IDLE;
      dec_escaped = 1'b0;
      dec_sum = 8'h00;
      dec_len = '0;
      dec_cmd = 4'h0;
      dec_port = 4'h0;
      dec_timer_on = 1'b0;
      dec_ticks = 16'h0000;
   endfunction

   function automatic kfd_pkg::result_type decode_item(input logic func,
                                                       input logic [7:0] c);
      kfd_pkg::result_type r;
      logic [7:0] b;
      r.byte_valid = 1'b0;
      r.byte_out = 8'h00;
      r.event_res = kfd_pkg::EV_NONE;
      r.frame_len = dec_len;
      r.cmd_code = dec_cmd;
      r.port_num = dec_port;
      if (func) begin
         if (dec_timer_on) begin
            if (dec_ticks != kfd_pkg::TICK_MAX) dec_ticks = dec_ticks + 16'd1;
            if (dec_ticks >= dec_timeout) begin
               clear_frame();
               r.event_res = kfd_pkg::EV_TIME;
            end
         end
      end else if (dec_phase == kfd_pkg::PH_HEAD) begin
         dec_cmd = c[3:0];
         dec_port = c[7:4];
         dec_phase = kfd_pkg::PH_BODY;
         r.cmd_code = dec_cmd;
         r.port_num = dec_port;
      end else if (dec_phase != kfd_pkg::PH_BODY) begin
         if (c == kfd_pkg::FEND) begin
            clear_frame();
            dec_phase = kfd_pkg::PH_HEAD;
            dec_timer_on = 1'b1;
         end
         r.frame_len = dec_len;
         r.cmd_code = dec_cmd;
         r.port_num = dec_port;
      end else if (c == kfd_pkg::FEND) begin
         if (dec_cmd != 4'h0 && dec_sum != kfd_pkg::SUM_OK) begin
            clear_frame();
            r.event_res = kfd_pkg::EV_CSUM;
         end else begin
            dec_phase = kfd_pkg::PH_IDLE;
            dec_escaped = 1'b0;
            dec_timer_on = 1'b0;
            r.event_res = kfd_pkg::EV_GOOD;
         end
      end else if (c == kfd_pkg::FESC) begin
         dec_escaped = 1'b1;
      end else begin
         if (dec_escaped && c == kfd_pkg::TFESC) b = kfd_pkg::FESC;
         else if (dec_escaped && c == kfd_pkg::TFEND) b = kfd_pkg::FEND;
         else b = c;
         dec_escaped = 1'b0;
         if (dec_len >= FRAME_CAP) begin
            clear_frame();
            r.event_res = kfd_pkg::EV_OVER;
         end else begin
            dec_len = dec_len + 10'd1;
            dec_sum = dec_sum + b;
            r.byte_valid = 1'b1;
            r.byte_out = b;
            r.frame_len = dec_len;
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return kfd_pkg::FEND;
         1: return kfd_pkg::FESC;
         2: return $urandom_range(0, 1) ? kfd_pkg::TFEND : kfd_pkg::TFESC;
         3: return $urandom_range(0, 1) ? 8'hff : 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("mismatch in %s: got %0h, expected %0h", what, got, want);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      kfd_pkg::result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_tdata, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser[0] !== want.byte_valid)
               report_mismatch("byte_valid", 32'(rsp_tuser[0]), 32'(want.byte_valid));
            if (rsp_tuser[3:1] !== want.event_res)
               report_mismatch("event_res", 32'(rsp_tuser[3:1]), 32'(want.event_res));
            if (rsp_tdata[7:0] !== want.byte_out)
               report_mismatch("byte_out", 32'(rsp_tdata[7:0]), 32'(want.byte_out));
            if (rsp_tdata[17:8] !== want.frame_len)
               report_mismatch("frame_len", 32'(rsp_tdata[17:8]), 32'(want.frame_len));
            if (rsp_tdata[21:18] !== want.cmd_code)
               report_mismatch("cmd_code", 32'(rsp_tdata[21:18]), 32'(want.cmd_code));
            if (rsp_tdata[25:22] !== want.port_num)
               report_mismatch("port_num", 32'(rsp_tdata[25:22]), 32'(want.port_num));
         end
      end
   end

   task automatic send_item(input logic func, input logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (func ? dec_timer_on : (dec_phase != kfd_pkg::PH_IDLE || data == kfd_pkg::FEND))
         live_items++;
      pending_results.push_back(decode_item(func, data));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_timeout(input logic [15:0] ticks);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= ticks;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dec_timeout = ticks;
   endtask

   // payload byte with escaping, now and then a doubled or stray escape
   task automatic send_payload(input logic [7:0] b);
      if (b == kfd_pkg::FEND || b == kfd_pkg::FESC) begin
         if ($urandom_range(0, 7) == 0) send_item(1'b0, kfd_pkg::FESC);
         send_item(1'b0, kfd_pkg::FESC);
         send_item(1'b0, (b == kfd_pkg::FEND) ? kfd_pkg::TFEND : kfd_pkg::TFESC);
      end else if ($urandom_range(0, 19) == 0) begin
         send_item(1'b0, kfd_pkg::FESC);
         send_item(1'b0, b);
      end else begin
         send_item(1'b0, b);
      end
   endtask

   task automatic maybe_tick();
      int n;
      if ($urandom_range(0, 39) == 0) begin
         n = $urandom_range(1, 50);
         repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 7) == 0) begin
         send_item(1'b1, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_random_frame();
      logic [7:0] hdr;
      logic [7:0] b;
      logic [7:0] sum;
      bit fix_sum;
      int n;
      int i;
      hdr = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) hdr[3:0] = 4'h0;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12);
      fix_sum = $urandom_range(0, 1);
      sum = 8'h00;
      send_item(1'b0, kfd_pkg::FEND);
      maybe_tick();
      send_item(1'b0, hdr);
      for (i = 0; i < n; i++) begin
         b = pick_byte();
         if (fix_sum && i == n - 1) b = kfd_pkg::SUM_OK - sum;
         sum = sum + b;
         send_payload(b);
         maybe_tick();
      end
      if ($urandom_range(0, 9) != 0) send_item(1'b0, kfd_pkg::FEND);
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 8);
      repeat (n) send_item($urandom_range(0, 3) == 0, pick_byte());
   endtask

   task automatic test_directed_frames();
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'h5a);
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hff);
      send_item(1'b0, kfd_pkg::FESC);
      send_item(1'b0, kfd_pkg::TFEND);
      send_item(1'b0, kfd_pkg::FESC);
      send_item(1'b0, kfd_pkg::FESC);
      send_item(1'b0, kfd_pkg::TFESC);
      send_item(1'b0, kfd_pkg::FESC);
      send_item(1'b0, 8'h41);
      send_item(1'b1, 8'hff);
      send_item(1'b0, kfd_pkg::FEND);
      // header byte equal to the frame delimiter
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b0, kfd_pkg::TFEND);
      send_item(1'b0, kfd_pkg::FEND);
      // checksum good, then checksum bad
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b0, 8'hff);
      send_item(1'b0, 8'h7f);
      send_item(1'b0, 8'h80);
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b0, 8'h21);
      send_item(1'b0, 8'h00);
      send_item(1'b0, kfd_pkg::FEND);
   endtask

   task automatic test_timeout();
      set_timeout(16'd1);
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b1, 8'h00);
      set_timeout(16'd3);
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b0, 8'h35);
      send_item(1'b1, 8'h00);
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'haa);
      send_item(1'b1, 8'h00);
      send_item(1'b1, 8'h00);
   endtask

   // fill the buffer, then an escaped byte that no longer fits
   task automatic test_overflow();
      set_timeout(16'hffff);
      send_item(1'b0, kfd_pkg::FEND);
      send_item(1'b0, 8'h00);
      repeat (FRAME_CAP) send_payload(pick_byte());
      send_item(1'b0, kfd_pkg::FESC);
      send_item(1'b0, kfd_pkg::TFEND);
      send_item(1'b0, 8'h55);
   endtask

   task automatic test_random_traffic(input int count, input logic [15:0] ticks,
                                      input bit quiet);
      int target;
      set_timeout(ticks);
      no_gaps = quiet;
      target = live_items + count;
      while (live_items < target) begin
         if ($urandom_range(0, 3) != 0) send_random_frame();
         else send_noise();
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      clear_frame();
      dec_timeout = kfd_pkg::TIMEOUT_RESET;
      @(posedge clock);
      test_directed_frames();
      test_timeout();
      test_overflow();
      test_random_traffic(200, 16'hffff, 1'b0);
      test_random_traffic(180, 16'd40, 1'b1);
      test_random_traffic(180, 16'd12, 1'b0);
      test_random_traffic(140, 16'd1, 1'b0);
      test_random_traffic(150, kfd_pkg::TIMEOUT_RESET, 1'b0);
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
src/kfd_pkg.sv
src/kfd_step.sv
src/kiss_frame_decoder_core.sv
tb/tb_top.sv
